FILE: hw/rtl/scma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scma_pkg
// Shared types, codes and constants of the sparse COO merge-add block.
// ----------------------------------------------------------------------------
package scma_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int PEND_DEPTH = 16;
    localparam int PTR_W      = $clog2(PEND_DEPTH);
    localparam int CNT_W      = $clog2(PEND_DEPTH + 1);
    localparam int DIM_W      = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_THR = 1'd1;

    typedef enum logic [1:0] {
        CMD_A     = 2'd0,
        CMD_B     = 2'd1,
        CMD_END_A = 2'd2,
        CMD_END_B = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        K_ENTRY = 2'd0,
        K_END   = 2'd1,
        K_ERR   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        E_ERR,
        E_END,
        E_HEAD,
        E_NEW,
        E_SUM
    } t_emit_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_END,
        S_DFETCH,
        S_DEMIT,
        S_FETCH,
        S_CMP,
        S_SUM,
        S_TAIL,
        S_FLUSH
    } t_state;

    typedef logic [MAX_DIMS-1:0][31:0] t_coords;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        coord_0;
        logic [31:0]        coord_1;
        logic [31:0]        coord_2;
        logic [31:0]        coord_3;
        logic signed [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        out_coord_0;
        logic [31:0]        out_coord_1;
        logic [31:0]        out_coord_2;
        logic [31:0]        out_coord_3;
        logic signed [31:0] out_value;
        logic               last_of_run;
    } t_out_item;

    typedef struct packed {
        logic      load;
        logic      set_fin;
        logic      emit;
        t_emit_sel sel;
        logic      flush;
        logic      pop;
        logic      store;
    } t_dp_cmd;

    typedef struct packed {
        logic is_end;
        logic mine_done;
        logic other_done;
        logic both_done;
        logic pend_other;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_full;
        logic cmp_lt;
        logic cmp_eq;
        logic keep;
        logic can_push;
    } t_dp_stat;

    // Zero acts as one, anything above MAX_DIMS as MAX_DIMS.
    function automatic logic [DIM_W-1:0] active_dims(input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] r;
        r = n;
        if (n == '0) r = DIM_W'(1);
        if (n > DIM_W'(MAX_DIMS)) r = DIM_W'(MAX_DIMS);
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/scma_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scma_datapath
// Pending store, item and result registers, coordinate compare and sum.
// ----------------------------------------------------------------------------
module scma_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire scma_pkg::t_in_item             i_in_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [scma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data,
    input  wire scma_pkg::t_dp_cmd              i_cmd,
    output scma_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output scma_pkg::t_out_item                 o_out_data
);
    import scma_pkg::*;

    typedef struct packed {
        t_coords     coords;
        logic [31:0] value;
    } t_pend_entry;

    t_pend_entry mem [PEND_DEPTH];
    t_pend_entry r_rd;

    logic [DIM_W-1:0] r_num_dims;
    logic [31:0]      r_thr;
    logic [1:0]       r_cmd;
    t_coords          r_coords;
    logic [31:0]      r_value;
    logic [31:0]      r_sum;
    logic [PTR_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic             r_side;
    logic             r_a_fin;
    logic             r_b_fin;
    logic             r_hold_valid;
    t_out_item        r_hold;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [DIM_W-1:0] nd;
    t_coords          in_coords;
    t_coords          masked;
    logic             side;
    logic             out_free;
    logic [PTR_W:0]   tail_sum;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] head_next;
    logic             lt;
    logic             eq;
    logic signed [32:0] sum33;
    logic signed [32:0] mag;
    t_out_item        n_hold;
    t_out_item        n_out;

    assign nd = active_dims(r_num_dims);
    assign in_coords = {i_in_data.coord_3, i_in_data.coord_2,
                        i_in_data.coord_1, i_in_data.coord_0};

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            masked[d] = (DIM_W'(d) < nd) ? in_coords[d] : 32'd0;
        end
    end

    assign side = (r_cmd == CMD_B) || (r_cmd == CMD_END_B);
    assign out_free = !r_out_valid || !i_out_stall;

    assign tail_sum = {1'b0, r_head} + (PTR_W+1)'(r_count);
    assign tail = (tail_sum >= (PTR_W+1)'(PEND_DEPTH))
                ? PTR_W'(tail_sum - (PTR_W+1)'(PEND_DEPTH)) : tail_sum[PTR_W-1:0];
    assign head_next = (r_head == PTR_W'(PEND_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);

    // Lexicographic compare of the head entry against the held item.
    always_comb begin
        lt = 1'b0;
        eq = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if ((DIM_W'(d) < nd) && eq) begin
                if (r_rd.coords[d] < r_coords[d]) begin
                    lt = 1'b1;
                    eq = 1'b0;
                end else if (r_rd.coords[d] > r_coords[d]) begin
                    eq = 1'b0;
                end
            end
        end
    end

    assign sum33 = {r_sum[31], r_sum};
    assign mag   = sum33[32] ? -sum33 : sum33;

    always_comb begin
        o_stat.is_end     = (r_cmd == CMD_END_A) || (r_cmd == CMD_END_B);
        o_stat.mine_done  = side ? r_b_fin : r_a_fin;
        o_stat.other_done = side ? r_a_fin : r_b_fin;
        o_stat.both_done  = r_a_fin && r_b_fin;
        o_stat.pend_other = (r_side != side);
        o_stat.cnt_zero   = (r_count == '0);
        o_stat.cnt_one    = (r_count == CNT_W'(1));
        o_stat.cnt_full   = (r_count >= CNT_W'(PEND_DEPTH));
        o_stat.cmp_lt     = lt;
        o_stat.cmp_eq     = eq;
        o_stat.keep       = $signed({r_thr[31], r_thr}) <= mag;
        o_stat.can_push   = !r_hold_valid || out_free;
    end

    always_comb begin
        n_hold = '0;
        case (i_cmd.sel)
            E_ERR: n_hold.kind = K_ERR;
            E_END: n_hold.kind = K_END;
            E_HEAD: begin
                n_hold.kind        = K_ENTRY;
                n_hold.out_coord_0 = r_rd.coords[0];
                n_hold.out_coord_1 = r_rd.coords[1];
                n_hold.out_coord_2 = r_rd.coords[2];
                n_hold.out_coord_3 = r_rd.coords[3];
                n_hold.out_value   = r_rd.value;
            end
            E_NEW, E_SUM: begin
                n_hold.kind        = K_ENTRY;
                n_hold.out_coord_0 = r_coords[0];
                n_hold.out_coord_1 = r_coords[1];
                n_hold.out_coord_2 = r_coords[2];
                n_hold.out_coord_3 = r_coords[3];
                n_hold.out_value   = (i_cmd.sel == E_SUM) ? r_sum : r_value;
            end
            default: n_hold = '0;
        endcase
    end

    always_comb begin
        n_out             = r_hold;
        n_out.last_of_run = i_cmd.flush;
    end

    // Pending store: write at the tail, read the head every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[tail] <= '{coords: r_coords, value: r_value};
        end
        r_rd  <= mem[r_head];
        r_sum <= r_rd.value + r_value;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_in_data.cmd;
            r_coords <= masked;
            r_value  <= i_in_data.entry_value;
        end
        if (i_cmd.emit) begin
            r_hold <= n_hold;
        end
        if ((i_cmd.emit || i_cmd.flush) && r_hold_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims   <= DIM_W'(2);
            r_thr        <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_side       <= 1'b0;
            r_a_fin      <= 1'b0;
            r_b_fin      <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_DIMS: r_num_dims <= i_cfg_data[DIM_W-1:0];
                    CFG_DROP_THR: r_thr      <= i_cfg_data;
                    default:      r_thr      <= r_thr;
                endcase
            end
            if (i_cmd.set_fin) begin
                if (side) r_b_fin <= 1'b1;
                else      r_a_fin <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_head  <= head_next;
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.store) begin
                r_count <= r_count + CNT_W'(1);
                r_side  <= side;
            end
            // Move the held result out once the next one or the end of run is known.
            if ((i_cmd.emit || i_cmd.flush) && r_hold_valid) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_hold_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: hw/rtl/scma_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scma_ctrl
// Sequencer for one input item: decide, drain, compare, store, close run.
// ----------------------------------------------------------------------------
module scma_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire scma_pkg::t_dp_stat i_stat,
    output scma_pkg::t_dp_cmd       o_cmd
);
    import scma_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.mine_done) begin
                    if (i_stat.can_push) n_state = S_FLUSH;
                end else if (i_stat.is_end) begin
                    n_state = S_END;
                end else if (!i_stat.cnt_zero && i_stat.pend_other) begin
                    n_state = S_FETCH;
                end else if (!i_stat.cnt_zero && i_stat.other_done) begin
                    n_state = S_DFETCH;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_END: begin
                if (!i_stat.cnt_zero && (i_stat.pend_other || i_stat.both_done)) begin
                    n_state = S_DFETCH;
                end else if (!i_stat.both_done || i_stat.can_push) begin
                    n_state = S_FLUSH;
                end
            end
            S_DFETCH: n_state = S_DEMIT;
            S_DEMIT: begin
                if (i_stat.can_push) begin
                    if (!i_stat.cnt_one)    n_state = S_DFETCH;
                    else if (i_stat.is_end) n_state = S_END;
                    else                    n_state = S_TAIL;
                end
            end
            S_FETCH: n_state = S_CMP;
            S_CMP: begin
                if (i_stat.cmp_eq) begin
                    n_state = S_SUM;
                end else if (i_stat.can_push) begin
                    if (!i_stat.cmp_lt)    n_state = S_FLUSH;
                    else if (i_stat.cnt_one) n_state = S_TAIL;
                    else                   n_state = S_FETCH;
                end
            end
            S_SUM: if (!i_stat.keep || i_stat.can_push) n_state = S_FLUSH;
            S_TAIL: begin
                if (!(i_stat.cnt_zero && i_stat.other_done) && !i_stat.cnt_full) begin
                    n_state = S_FLUSH;
                end else if (i_stat.can_push) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: if (i_stat.can_push) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = E_ERR;
        o_in_stall = (r_state != S_IDLE) || !i_rst_n;
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_DECIDE: begin
                if (i_stat.mine_done) begin
                    o_cmd.emit = i_stat.can_push;
                    o_cmd.sel  = E_ERR;
                end else if (i_stat.is_end) begin
                    o_cmd.set_fin = 1'b1;
                end
            end
            S_END: begin
                if (!(!i_stat.cnt_zero && (i_stat.pend_other || i_stat.both_done))
                    && i_stat.both_done) begin
                    o_cmd.emit = i_stat.can_push;
                    o_cmd.sel  = E_END;
                end
            end
            S_DEMIT: begin
                o_cmd.emit = i_stat.can_push;
                o_cmd.pop  = i_stat.can_push;
                o_cmd.sel  = E_HEAD;
            end
            S_CMP: begin
                if (!i_stat.cmp_eq) begin
                    o_cmd.emit = i_stat.can_push;
                    o_cmd.pop  = i_stat.can_push && i_stat.cmp_lt;
                    o_cmd.sel  = i_stat.cmp_lt ? E_HEAD : E_NEW;
                end
            end
            S_SUM: begin
                // Drop a colliding sum below the threshold, pop either way.
                o_cmd.sel  = E_SUM;
                o_cmd.emit = i_stat.keep && i_stat.can_push;
                o_cmd.pop  = !i_stat.keep || i_stat.can_push;
            end
            S_TAIL: begin
                if (i_stat.cnt_zero && i_stat.other_done) begin
                    o_cmd.emit = i_stat.can_push;
                    o_cmd.sel  = E_NEW;
                end else if (i_stat.cnt_full) begin
                    o_cmd.emit = i_stat.can_push;
                    o_cmd.sel  = E_ERR;
                end else begin
                    o_cmd.store = 1'b1;
                end
            end
            S_FLUSH: o_cmd.flush = i_stat.can_push;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sparse_coo_merge_add.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_coo_merge_add
// Merge-add of two index-sorted sparse COO lists into one ordered list.
// ----------------------------------------------------------------------------
// One input item is taken at a time: a new item is not accepted until the
// previous one is finished. Each item is accepted and decided, then each
// pending entry visited by a compare or drain takes a registered read of the
// pending store head and a compare or emit step, a collision adds a sum check
// step, the store, pass-through, full check or end-marker step follows unless
// a compare settles the item, and a final step closes the run; an item
// rejected after its list ended is only decided and closed. All of this
// takes longer when the output stalls.
// Results leave through a one-deep hold register so the last result of each
// run can be flagged, then an output register.
module sparse_coo_merge_add (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire scma_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output scma_pkg::t_out_item                 o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [scma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);
    import scma_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    scma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    scma_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
